// ===== rtl/core/rfbr_pkg.sv =====
// Shared constants, operation and status codes and the result type for the
// batch-read ring FIFO. No dependencies.
package rfbr_pkg;

   localparam int unsigned DEPTH_DEFAULT      = 16;
   localparam int unsigned DATA_WIDTH_DEFAULT = 32;

   localparam int unsigned OPCODE_W    = 2;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned RSP_TDATA_W = 56;

   localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_BEGIN  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_NEXT   = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_COMMIT = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_BATCH  = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                data_valid;
      logic [COUNT_W-1:0]  batch_count;
      logic [COUNT_W-1:0]  fill_count;
      logic [COUNT_W-1:0]  free_space;
      logic                is_empty;
      logic                is_full;
   } rsp_info_type;

endpackage

// ===== rtl/core/rfbr_store.sv =====
// Slot store of the ring FIFO: one write port, one read port with registered
// read data. Depends on rfbr_pkg.
module rfbr_store import rfbr_pkg::*; #(
   parameter int unsigned DEPTH      = DEPTH_DEFAULT,
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WORD_W-1:0]                     wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WORD_W-1:0]                     rd_data
);

   logic [DATA_WIDTH-1:0]        mem [DEPTH];
   logic [DATA_WIDTH-1:0]        rd_q_ff;
   logic [DATA_WIDTH+WORD_W-1:0] wr_wide;
   logic [DATA_WIDTH+WORD_W-1:0] rd_wide;

   assign wr_wide = {{DATA_WIDTH{1'b0}}, wr_data};
   assign rd_wide = {{WORD_W{1'b0}}, rd_q_ff};
   assign rd_data = rd_wide[WORD_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_wide[DATA_WIDTH-1:0];
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/rfbr_ctrl.sv =====
// Pointer and batch control of the ring FIFO: decodes each request, updates
// head, tail and snapshot bounds, registers the result. Depends on rfbr_pkg.
module rfbr_ctrl import rfbr_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [OPCODE_W-1:0]                   opcode,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rsp_info_type                          info,
   output logic                                  wr_en,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   output logic                                  rd_en,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] CAPACITY = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] bstart_ff, bstart_in;
   logic [PTR_W-1:0] cursor_ff, cursor_in;
   logic [PTR_W-1:0] bend_ff, bend_in;
   logic             open_ff, open_in;
   logic             valid_ff, valid_in;
   rsp_info_type     info_ff, info_in;

   logic                     accept;
   logic                     push_ok;
   logic                     next_ok;
   logic [STATUS_W-1:0]      status;
   logic [PTR_W-1:0]         fill_now, fill_next, free_next, bcount;
   logic [PTR_W+COUNT_W-1:0] fill_wide, free_wide, bcount_wide;

   assign req_ready = ~valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign fill_now  = tail_ff - head_ff;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      bstart_in = bstart_ff;
      cursor_in = cursor_ff;
      bend_in   = bend_ff;
      open_in   = open_ff;
      status    = ST_OK;
      push_ok   = 1'b0;
      next_ok   = 1'b0;
      bcount    = '0;
      unique case (opcode)
         OP_PUSH: begin
            if (fill_now == CAPACITY) begin
               status = ST_FULL;
            end else begin
               push_ok = 1'b1;
               tail_in = tail_ff + PTR_W'(1);
            end
         end
         OP_BEGIN: begin
            if (head_ff == tail_ff) begin
               status  = ST_EMPTY;
               open_in = 1'b0;
            end else begin
               bstart_in = head_ff;
               cursor_in = head_ff;
               bend_in   = tail_ff;
               open_in   = 1'b1;
               bcount    = fill_now;
            end
         end
         OP_NEXT: begin
            if (!open_ff || cursor_ff == bend_ff) begin
               status = ST_EXHAUSTED;
            end else begin
               next_ok   = 1'b1;
               cursor_in = cursor_ff + PTR_W'(1);
            end
         end
         OP_COMMIT: begin
            if (!open_ff || head_ff != bstart_ff) begin
               status = ST_NO_BATCH;
            end else begin
               head_in = cursor_ff;
               open_in = 1'b0;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign fill_next   = tail_in - head_in;
   assign free_next   = CAPACITY - fill_next;
   assign fill_wide   = {{COUNT_W{1'b0}}, fill_next};
   assign free_wide   = {{COUNT_W{1'b0}}, free_next};
   assign bcount_wide = {{COUNT_W{1'b0}}, bcount};

   always_comb begin
      info_in.status      = status;
      info_in.data_valid  = next_ok;
      info_in.batch_count = bcount_wide[COUNT_W-1:0];
      info_in.fill_count  = fill_wide[COUNT_W-1:0];
      info_in.free_space  = free_wide[COUNT_W-1:0];
      info_in.is_empty    = (head_in == tail_in);
      info_in.is_full     = (fill_next == CAPACITY);
      valid_in            = accept | (valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         bstart_ff <= '0;
         cursor_ff <= '0;
         bend_ff   <= '0;
         open_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            bstart_ff <= bstart_in;
            cursor_ff <= cursor_in;
            bend_ff   <= bend_in;
            open_ff   <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= info_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign info      = info_ff;
   assign wr_en     = accept & push_ok;
   assign wr_addr   = tail_ff;
   assign rd_en     = accept;
   assign rd_addr   = cursor_ff;

endmodule

// ===== rtl/core/ring_fifo_batch_read.sv =====
// Top level of the batch-read ring FIFO: stream ports, control and slot store.
// Depends on rfbr_pkg, rfbr_ctrl and rfbr_store.
//
// Ring FIFO of DEPTH slots holding up to DEPTH-1 words, with a batch reader:
// push (opcode 0), begin batch (1), next of batch (2), commit batch (3). One
// request is taken per cycle while req_tready is high, and each gives exactly
// one result, in the cycle after acceptance; the result is registered in the
// control and in the read port of the slot store, which hold it while stalled.
// req_tready drops only while a result is waiting and rsp_tready is low.
// Slots need no clearing after reset: only words already pushed are read.
module ring_fifo_batch_read import rfbr_pkg::*; #(
   parameter int unsigned DEPTH      = DEPTH_DEFAULT,
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // opcode[1:0], write_data[33:2], zero pad[39:34]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[2:0], read_data[34:3], data_valid[35], batch_count[39:36],
   // fill_count[43:40], free_space[47:44], is_empty[48], is_full[49], pad[55:50]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rsp_info_type      info;
   logic              wr_en;
   logic              rd_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [PTR_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic [WORD_W-1:0] read_data;

   rfbr_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .opcode    (req_tdata[OPCODE_W-1:0]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .info      (info),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr)
   );

   rfbr_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[OPCODE_W+WORD_W-1:OPCODE_W]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign read_data = info.data_valid ? rd_data : '0;

   assign rsp_tdata = {6'd0, info.is_full, info.is_empty, info.free_space,
                       info.fill_count, info.batch_count, info.data_valid,
                       read_data, info.status};

endmodule

// ===== rtl/core/rfbr_checker.sv =====
// Port-level checks for ring_fifo_batch_read, bound to the top level.
// Depends on rfbr_pkg and ring_fifo_batch_read.
module rfbr_checker import rfbr_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[2:0] == ST_OK)
      else $error("element returned with a non-ok status");

   a_full_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49] |-> rsp_tdata[47:44] == 4'd0 && !rsp_tdata[48])
      else $error("full flag inconsistent with free space");

   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ST_FULL |-> rsp_tdata[49])
      else $error("push refused while not full");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[48] |-> rsp_tdata[43:40] == 4'd0)
      else $error("empty flag with nonzero fill count");

endmodule

bind ring_fifo_batch_read rfbr_checker u_rfbr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_ring_fifo_batch_read.sv =====
// Self-checking testbench for ring_fifo_batch_read: a directed table, partly with fixed
// expected results, then random push bursts and batch reads; other results are checked
// against an in-bench model of the ring. Depends on rfbr_pkg and the ring_fifo_batch_read RTL.
module tb_ring_fifo_batch_read;
   import rfbr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH      = DEPTH_DEFAULT;
   localparam int unsigned CAPACITY   = DEPTH - 1;
   localparam int unsigned HOLD_LIMIT = 4000;
   localparam int unsigned LONG_HOLD  = 400;
   localparam int unsigned PHASE_ITEMS = 250;

   // same layout as rsp_tdata, lowest field last
   typedef struct packed {
      logic [5:0]          pad;
      logic                is_full;
      logic                is_empty;
      logic [COUNT_W-1:0]  free_space;
      logic [COUNT_W-1:0]  fill_count;
      logic [COUNT_W-1:0]  batch_count;
      logic                data_valid;
      logic [WORD_W-1:0]   read_data;
      logic [STATUS_W-1:0] status;
   } fifo_result_type;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [WORD_W-1:0]   word;
      bit                  typed;
      fifo_result_type     want;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // model of the ring
   logic [WORD_W-1:0]  slot_words [DEPTH];
   logic [COUNT_W-1:0] rd_pos, wr_pos, snap_start, snap_cursor, snap_end;
   bit                 snap_open;

   fifo_result_type fifo_replies_due [$];
   int unsigned  mismatch_count;
   int unsigned  requests_sent;
   int unsigned  replies_seen;
   int unsigned  quiet_cycles;
   int unsigned  tx_idle_pct, rx_idle_pct;
   int unsigned  hold_left;
   bit           long_hold_due;

   stim_row_type directed_rows [21] = '{
      '{OP_COMMIT, 32'h0, 1'b1,
        '{status: ST_NO_BATCH, free_space: 4'd15, is_empty: 1'b1, default: '0}},
      '{OP_NEXT, 32'h0, 1'b1,
        '{status: ST_EXHAUSTED, free_space: 4'd15, is_empty: 1'b1, default: '0}},
      '{OP_BEGIN, 32'h0, 1'b1,
        '{status: ST_EMPTY, free_space: 4'd15, is_empty: 1'b1, default: '0}},
      '{OP_PUSH, 32'hFFFF_FFFF, 1'b1,
        '{status: ST_OK, fill_count: 4'd1, free_space: 4'd14, default: '0}},
      '{OP_PUSH, 32'h0000_0000, 1'b1,
        '{status: ST_OK, fill_count: 4'd2, free_space: 4'd13, default: '0}},
      '{OP_BEGIN, 32'h0, 1'b1,
        '{status: ST_OK, batch_count: 4'd2, fill_count: 4'd2, free_space: 4'd13,
          default: '0}},
      '{OP_PUSH,   32'hA5A5_A5A5, 1'b0, '0},
      '{OP_NEXT,   32'h0, 1'b0, '0},
      '{OP_NEXT,   32'h0, 1'b0, '0},
      '{OP_NEXT,   32'h0, 1'b0, '0},
      '{OP_COMMIT, 32'h0, 1'b0, '0},
      '{OP_COMMIT, 32'h0, 1'b0, '0},
      '{OP_BEGIN,  32'h0, 1'b0, '0},
      '{OP_NEXT,   32'h0, 1'b0, '0},
      '{OP_BEGIN,  32'h0, 1'b0, '0},
      '{OP_NEXT,   32'h0, 1'b0, '0},
      '{OP_COMMIT, 32'h0, 1'b0, '0},
      '{OP_PUSH,   32'h5A5A_5A5A, 1'b0, '0},
      '{OP_NEXT,   32'h0, 1'b0, '0},
      '{OP_BEGIN,  32'h0, 1'b0, '0},
      '{OP_COMMIT, 32'h0, 1'b0, '0}
   };

   ring_fifo_batch_read dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic fifo_result_type ring_apply(input logic [OPCODE_W-1:0] op,
                                                  input logic [WORD_W-1:0] word);
      fifo_result_type    r;
      logic [COUNT_W-1:0] fill;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH: begin
            if (COUNT_W'(wr_pos - rd_pos) == COUNT_W'(CAPACITY)) begin
               r.status = ST_FULL;
            end else begin
               slot_words[wr_pos] = word;
               wr_pos = wr_pos + 1'b1;
            end
         end
         OP_BEGIN: begin
            if (rd_pos == wr_pos) begin
               r.status = ST_EMPTY;
               snap_open = 1'b0;
            end else begin
               snap_start  = rd_pos;
               snap_cursor = rd_pos;
               snap_end    = wr_pos;
               snap_open   = 1'b1;
               r.batch_count = wr_pos - rd_pos;
            end
         end
         OP_NEXT: begin
            if (!snap_open || snap_cursor == snap_end) begin
               r.status = ST_EXHAUSTED;
            end else begin
               r.read_data  = slot_words[snap_cursor];
               r.data_valid = 1'b1;
               snap_cursor  = snap_cursor + 1'b1;
            end
         end
         default: begin
            if (!snap_open || rd_pos != snap_start) begin
               r.status = ST_NO_BATCH;
            end else begin
               rd_pos    = snap_cursor;
               snap_open = 1'b0;
            end
         end
      endcase
      fill = wr_pos - rd_pos;
      r.fill_count = fill;
      r.free_space = COUNT_W'(CAPACITY) - fill;
      r.is_empty   = (rd_pos == wr_pos);
      r.is_full    = (fill == COUNT_W'(CAPACITY));
      return r;
   endfunction

   task automatic issue_request(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] word,
                                input bit typed, input fifo_result_type want);
      fifo_result_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - WORD_W - OPCODE_W){1'b0}}, word, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = ring_apply(op, word);
      fifo_replies_due.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_traffic(input int unsigned stop_at);
      int unsigned n;
      while (requests_sent < stop_at) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               n = $urandom_range(1, 18);
               repeat (n) issue_request(OP_PUSH, pick_word(), 1'b0, '0);
            end
            4, 5, 6, 7: begin
               issue_request(OP_BEGIN, $urandom, 1'b0, '0);
               n = $urandom_range(0, int'(COUNT_W'(wr_pos - rd_pos)) + 2);
               repeat (n) issue_request(OP_NEXT, $urandom, 1'b0, '0);
               if ($urandom_range(9) < 8) issue_request(OP_COMMIT, $urandom, 1'b0, '0);
            end
            default: issue_request(OPCODE_W'($urandom_range(3)), pick_word(), 1'b0, '0);
         endcase
      end
   endtask

   task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("reply %0d: %s got 0x%0h, expected 0x%0h", replies_seen, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         fifo_result_type got, want;
         got = fifo_result_type'(rsp_tdata);
         if (fifo_replies_due.size() == 0) begin
            report_mismatch("unexpected reply", rsp_tdata[WORD_W-1:0], '0);
         end else begin
            want = fifo_replies_due.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
            if (got.read_data !== want.read_data)
               report_mismatch("read_data", got.read_data, want.read_data);
            if (got.data_valid !== want.data_valid)
               report_mismatch("data_valid", WORD_W'(got.data_valid),
                               WORD_W'(want.data_valid));
            if (got.batch_count !== want.batch_count)
               report_mismatch("batch_count", WORD_W'(got.batch_count),
                               WORD_W'(want.batch_count));
            if (got.fill_count !== want.fill_count)
               report_mismatch("fill_count", WORD_W'(got.fill_count),
                               WORD_W'(want.fill_count));
            if (got.free_space !== want.free_space)
               report_mismatch("free_space", WORD_W'(got.free_space),
                               WORD_W'(want.free_space));
            if (got.is_empty !== want.is_empty)
               report_mismatch("is_empty", WORD_W'(got.is_empty), WORD_W'(want.is_empty));
            if (got.is_full !== want.is_full)
               report_mismatch("is_full", WORD_W'(got.is_full), WORD_W'(want.is_full));
         end
         replies_seen++;
      end
   end

   // result side pacing, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (long_hold_due) begin
         long_hold_due = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HOLD_LIMIT) begin
         $display("ring_fifo_batch_read verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      mismatch_count = 0;
      requests_sent = 0;
      replies_seen = 0;
      quiet_cycles = 0;
      hold_left = 0;
      long_hold_due = 1'b0;
      tx_idle_pct = 9;
      rx_idle_pct = 83;
      rd_pos = '0;
      wr_pos = '0;
      snap_start = '0;
      snap_cursor = '0;
      snap_end = '0;
      snap_open = 1'b0;
      foreach (slot_words[i]) slot_words[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue_request(directed_rows[i].op, directed_rows[i].word,
                       directed_rows[i].typed, directed_rows[i].want);

      random_traffic(requests_sent + PHASE_ITEMS);
      tx_idle_pct = 83;
      rx_idle_pct = 9;
      random_traffic(requests_sent + PHASE_ITEMS);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      long_hold_due = 1'b1;
      random_traffic(requests_sent + PHASE_ITEMS);
      req_tvalid <= 1'b0;

      while (fifo_replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ring_fifo_batch_read verification clean");
      end else begin
         $display("ring_fifo_batch_read verification failed");
      end
      $finish;
   end

endmodule
